### rtl/wrsd_pkg.sv
// wrsd_pkg: shared constants, register indexes and control structs for the
// window range stability detector. No dependencies.
`default_nettype none

package wrsd_pkg;

    localparam int WRSD_STORE_DEPTH = 512;
    localparam int WRSD_SAMPLE_BITS = 24;

    localparam int WLEN_BITS    = 10;
    localparam int TOL_BITS     = 25;
    localparam int CFG_IDX_BITS = 1;
    localparam int CFG_DAT_BITS = 25;
    localparam int OUT_BYTES    = 8;

    localparam logic [WLEN_BITS-1:0] WLEN_RESET = 10'd512;

    localparam logic [CFG_IDX_BITS-1:0] REG_WLEN = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_TOL  = 1'b1;

    typedef struct packed {
        logic write;      // store accepted sample, advance index
        logic scan_step;  // issue one store read
        logic load_out;   // move result into output register
    } t_dp_cmd;

    typedef struct packed {
        logic full;       // window full after last write
        logic scan_last;  // current read address is last of window
    } t_dp_stat;

endpackage

`default_nettype wire

### rtl/wrsd_ctrl.sv
// wrsd_ctrl: sequencer for write, scan and result hand-off.
// Depends on wrsd_pkg.
`default_nettype none

module wrsd_ctrl
    import wrsd_pkg::*;
(
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  wire           i_out_ready,
    output t_dp_cmd       o_cmd,
    input  wire t_dp_stat i_stat
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       slot_free;

    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_cmd.write     = (r_state == S_IDLE) && i_in_valid;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (!i_stat.full) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.scan_step = 1'b1;
                    if (i_stat.scan_last) n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_DONE;
            S_DONE: begin
                if (slot_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;
        if (o_cmd.load_out)             n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

### rtl/wrsd_datapath.sv
// wrsd_datapath: sample store, write index, full flag, config registers,
// min/max scan and result register. Depends on wrsd_pkg.
`default_nettype none

module wrsd_datapath
    import wrsd_pkg::*;
#(
    parameter int STORE_DEPTH = WRSD_STORE_DEPTH,
    parameter int SAMPLE_BITS = WRSD_SAMPLE_BITS
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_cfg_we,
    input  wire  [CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire  [CFG_DAT_BITS-1:0] i_cfg_data,
    input  wire  [SAMPLE_BITS-1:0]  i_sample,
    input  wire  t_dp_cmd           i_cmd,
    output t_dp_stat                o_stat,
    output logic                    o_stable,
    output logic                    o_window_full
);

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int LW = AW + 1;
    localparam int DW = SAMPLE_BITS + 1;
    localparam int CW = (DW > TOL_BITS) ? DW : TOL_BITS;

    logic [SAMPLE_BITS-1:0] mem [STORE_DEPTH];

    logic [WLEN_BITS-1:0]   r_wlen;
    logic [TOL_BITS-1:0]    r_tol;
    logic [AW-1:0]          r_wr_idx;
    logic                   r_full;
    logic [AW-1:0]          r_scan_idx;
    logic [SAMPLE_BITS-1:0] r_rd_data;
    logic                   r_rd_vld;
    logic                   r_rd_first;
    logic signed [SAMPLE_BITS-1:0] r_lo, r_hi;
    logic                   r_out_stable, r_out_full;

    logic [LW-1:0] eff_len;
    logic [LW-1:0] pos_inc;
    logic [DW-1:0] range;
    logic          stable_now;
    logic signed [SAMPLE_BITS-1:0] rd_s;

    // zero length acts as one, long window clips to store depth
    always_comb begin
        if (r_wlen == '0) begin
            eff_len = LW'(1);
        end else if (32'(r_wlen) > 32'(STORE_DEPTH)) begin
            eff_len = LW'(STORE_DEPTH);
        end else begin
            eff_len = LW'(r_wlen);
        end
    end

    assign pos_inc          = {1'b0, r_wr_idx} + LW'(1);
    assign o_stat.full      = r_full;
    assign o_stat.scan_last = ({1'b0, r_scan_idx} == (eff_len - LW'(1)));

    assign rd_s       = $signed(r_rd_data);
    assign range      = DW'($signed({r_hi[SAMPLE_BITS-1], r_hi})
                          - $signed({r_lo[SAMPLE_BITS-1], r_lo}));
    assign stable_now = r_full && (CW'(range) < CW'(r_tol));

    assign o_stable      = r_out_stable;
    assign o_window_full = r_out_full;

    // store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.write) mem[r_wr_idx] <= i_sample;
        if (i_cmd.scan_step) r_rd_data <= mem[r_scan_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen     <= WLEN_RESET;
            r_tol      <= '0;
            r_wr_idx   <= '0;
            r_full     <= 1'b0;
            r_rd_vld   <= 1'b0;
            r_scan_idx <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_WLEN: r_wlen <= i_cfg_data[WLEN_BITS-1:0];
                    REG_TOL:  r_tol  <= i_cfg_data[TOL_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.write) begin
                r_scan_idx <= '0;
                if (pos_inc >= eff_len) begin
                    r_wr_idx <= '0;
                    r_full   <= 1'b1;
                end else begin
                    r_wr_idx <= pos_inc[AW-1:0];
                end
            end
            r_rd_vld <= i_cmd.scan_step;
            if (i_cmd.scan_step) r_scan_idx <= r_scan_idx + AW'(1);
        end
    end

    // running min/max and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step) r_rd_first <= (r_scan_idx == '0);
        if (r_rd_vld) begin
            if (r_rd_first) begin
                r_lo <= rd_s;
                r_hi <= rd_s;
            end else begin
                if (rd_s < r_lo) r_lo <= rd_s;
                if (rd_s > r_hi) r_hi <= rd_s;
            end
        end
        if (i_cmd.load_out) begin
            r_out_stable <= stable_now;
            r_out_full   <= r_full;
        end
    end

endmodule

`default_nettype wire

### rtl/window_range_stability_detector_core.sv
// Window range stability detector, top level: controller plus datapath.
// When the window is full, each request scans L entries, where L is the
// effective window length (zero counts as one, clipped to the store
// depth): one store read per window entry through the single read port.
// Before the window is full no scan is done. Requests do not overlap, but
// the next request is taken while a result still waits on the output.
// Reset (sync, active low) clears index, full flag and handshake state and
// restores the config registers to their defaults; the store is not cleared.
`default_nettype none

module window_range_stability_detector_core
    import wrsd_pkg::*;
#(
    parameter int STORE_DEPTH = WRSD_STORE_DEPTH,
    parameter int SAMPLE_BITS = WRSD_SAMPLE_BITS
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // config write channel: index 0 window_length, 1 tolerance
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire  [CFG_IDX_BITS-1:0]           i_cfg_index,
    input  wire  [CFG_DAT_BITS-1:0]           i_cfg_data,
    // input stream
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire  [((SAMPLE_BITS+7)/8)*8-1:0]  s_axis_tdata,  // sample
    // result stream
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    output logic [OUT_BYTES-1:0]              m_axis_tdata   // stable, window_full
);

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     stable, window_full;

    // config must be written only while idle; the core does not enforce it, so it is always taken
    assign o_cfg_ready = 1'b1;

    wrsd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    wrsd_datapath #(
        .STORE_DEPTH (STORE_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_sample      (s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_stable      (stable),
        .o_window_full (window_full)
    );

    // result packing: bit 0 stable, bit 1 window_full, rest zero
    assign m_axis_tdata = {{(OUT_BYTES-2){1'b0}}, window_full, stable};

endmodule

`default_nettype wire

### bench/wrsd_result_checker.sv
// wrsd_result_checker: watches the config, sample and result channels of the
// window range stability detector, predicts each result and compares it.
// Depends on wrsd_pkg for widths, register indexes and reset values.

module wrsd_result_checker
    import wrsd_pkg::*;
(
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_valid,
    input  wire                          i_cfg_ready,
    input  wire  [CFG_IDX_BITS-1:0]      i_cfg_index,
    input  wire  [CFG_DAT_BITS-1:0]      i_cfg_data,
    input  wire                          i_in_valid,
    input  wire                          i_in_ready,
    input  wire  [WRSD_SAMPLE_BITS-1:0]  i_in_data,
    input  wire                          i_out_valid,
    input  wire                          i_out_ready,
    input  wire  [OUT_BYTES-1:0]         i_out_data,
    output int                           o_fail_count,
    output int                           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // bit 0 stable, bit 1 window_full
    typedef struct packed {
        logic window_full;
        logic stable;
    } t_flags;

    logic signed [WRSD_SAMPLE_BITS-1:0] window_samples [WRSD_STORE_DEPTH];
    logic [WLEN_BITS-1:0] cfg_wlen;
    logic [TOL_BITS-1:0]  cfg_tol;
    int unsigned          wr_pos;
    logic                 win_full;
    t_flags               expected_flags [$];
    int                   fails;
    int                   results_seen;

    // Store the sample, advance the index, then, once the window is full, scan it for min/max.
    function automatic t_flags predict_flags(
        input logic signed [WRSD_SAMPLE_BITS-1:0] sample);
        int unsigned span;
        int unsigned pos;
        longint      lo;
        longint      hi;
        t_flags      r;
        span = (cfg_wlen == 0) ? 1 :
               ((cfg_wlen > WRSD_STORE_DEPTH) ? WRSD_STORE_DEPTH : cfg_wlen);
        pos = (wr_pos >= WRSD_STORE_DEPTH) ? 0 : wr_pos;
        window_samples[pos] = sample;
        pos++;
        if (pos >= span) begin
            win_full = 1'b1;
            pos = 0;
        end
        wr_pos = pos;
        r.stable = 1'b0;
        r.window_full = win_full;
        if (win_full) begin
            lo = window_samples[0];
            hi = window_samples[0];
            for (int i = 1; i < span; i++) begin
                if (window_samples[i] < lo) lo = window_samples[i];
                if (window_samples[i] > hi) hi = window_samples[i];
            end
            r.stable = (hi - lo) < longint'(cfg_tol);
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_flags want;
        t_flags got;
        if (!i_rst_n) begin
            cfg_wlen = WLEN_RESET;
            cfg_tol = '0;
            wr_pos = 0;
            win_full = 1'b0;
            fails = 0;
            results_seen = 0;
            expected_flags.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_WLEN: cfg_wlen = i_cfg_data[WLEN_BITS-1:0];
                    REG_TOL:  cfg_tol  = i_cfg_data[TOL_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                got = t_flags'(i_out_data[1:0]);
                if (expected_flags.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: result %0d with no request pending (stable=%0b full=%0b)",
                            $realtime, results_seen, got.stable, got.window_full);
                end else begin
                    want = expected_flags.pop_front();
                    if (got.stable !== want.stable || got.window_full !== want.window_full) begin
                        fails++;
                        if (fails <= 10)
                            $display({"%0t: result %0d expected stable=%0b full=%0b,",
                                      " got stable=%0b full=%0b"},
                                $realtime, results_seen, want.stable, want.window_full,
                                got.stable, got.window_full);
                    end
                end
                results_seen++;
            end
            if (i_in_valid && i_in_ready)
                expected_flags.insert(expected_flags.size(),
                                      predict_flags($signed(i_in_data)));
        end
        o_fail_count <= fails;
        o_pending <= expected_flags.size();
    end

endmodule

### bench/window_range_stability_detector_core_test.sv
// Top of the window range stability detector bench: clock, reset, stimulus,
// idling and verdict. Depends on wrsd_pkg, the core and wrsd_result_checker.

module window_range_stability_detector_core_test;
    import wrsd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOTAL_ITEMS    = 1160;
    localparam int FILL_ITEMS     = WRSD_STORE_DEPTH;
    localparam int QUIET_ITEMS    = 120;   // tail of the run without idling
    localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
    // worst quiet stretch: full-store scan + both idle bursts + the hold-off
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = WRSD_STORE_DEPTH + 8;

    typedef enum int {MODE_WIDE, MODE_CLUSTER, MODE_CORNER} t_draw_mode;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_cfg_valid = 1'b0;
    logic                        o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]     i_cfg_index = REG_WLEN;
    logic [CFG_DAT_BITS-1:0]     i_cfg_data = '0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [WRSD_SAMPLE_BITS-1:0] s_axis_tdata = '0;     // sample
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [OUT_BYTES-1:0]        m_axis_tdata;          // stable, window_full

    int fail_count;
    int pending;
    int sent = 0;
    int tx_idle_pct = 0;    // read only by the stimulus process
    int rx_idle_pct = 0;    // handed to the receiver process
    int hold_seq = 0;       // bumped to ask for one long hold-off
    int hold_seen = 0;
    int hold_left = 0;
    int rx_gap = 0;
    int idle_cycles = 0;

    always #2 i_clk = ~i_clk;

    window_range_stability_detector_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    wrsd_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Receiver side. A hold request (hold_seq change) wins over everything but
    // reset and keeps tready low for HOLD_CYCLES so the core backs up into its input.
    // Otherwise random-length low bursts at rx_idle_pct.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_left <= 0;
            rx_gap <= 0;
        end else if (hold_seen != hold_seq) begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            m_axis_tready <= 1'b0;
        end else if (rx_idle_pct > 0 && $urandom_range(99) < rx_idle_pct) begin
            rx_gap <= $urandom_range(0, 8);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Watchdog: any accepted request on any channel restarts the count.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Sample generators: full 24-bit range, a cluster from a random center up to
    // center + spread (wrapping past the top), or the corner values only.
    function automatic logic [WRSD_SAMPLE_BITS-1:0] draw_sample(
        input t_draw_mode mode, input logic [WRSD_SAMPLE_BITS-1:0] center, input int spread);
        logic [WRSD_SAMPLE_BITS-1:0] corners [4];
        corners = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF};
        case (mode)
            MODE_CLUSTER: return center + WRSD_SAMPLE_BITS'($urandom_range(0, spread));
            MODE_CORNER:  return corners[$urandom_range(0, 3)];
            default:      return WRSD_SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // One sample request; optional idle burst in front of it. tvalid stays
    // high after the handshake so back-to-back requests need no re-raise.
    task automatic send_sample(input logic [WRSD_SAMPLE_BITS-1:0] value);
        int gap;
        if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            gap = $urandom_range(1, 9);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= value;
        do @(posedge i_clk); while (!s_axis_tready);
        sent++;
    endtask

    // Leaves i_cfg_valid high; the caller drops it after the last write.
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DAT_BITS-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Sender pause: stop offering and wait for every outstanding result.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Drain, reprogram both registers (random order), then stream count samples.
    task automatic run_phase(input int len, input logic [TOL_BITS-1:0] tol, input int count,
                             input t_draw_mode mode, input int spread,
                             input int tx_pct, input int rx_pct, input bit hold);
        logic [WRSD_SAMPLE_BITS-1:0] center;
        wait_idle();
        if ($urandom_range(1)) begin
            write_reg(REG_WLEN, CFG_DAT_BITS'(len));
            write_reg(REG_TOL, CFG_DAT_BITS'(tol));
        end else begin
            write_reg(REG_TOL, CFG_DAT_BITS'(tol));
            write_reg(REG_WLEN, CFG_DAT_BITS'(len));
        end
        i_cfg_valid <= 1'b0;
        tx_idle_pct = tx_pct;
        rx_idle_pct <= rx_pct;
        if (hold)
            hold_seq <= hold_seq + 1;
        center = WRSD_SAMPLE_BITS'($urandom);
        repeat (count) send_sample(draw_sample(mode, center, spread));
    endtask

    initial begin
        logic [WRSD_SAMPLE_BITS-1:0] corner_samples [8];
        int         len;
        int         count;
        int         spread;
        int         pick;
        int         tx_pct;
        int         rx_pct;
        bit         hold;
        t_draw_mode mode;
        logic [TOL_BITS-1:0] tol;

        corner_samples = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF,
                           24'h000001, 24'h555555, 24'hAAAAAA, 24'h7FFFFE};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings (full-depth window, zero tolerance): fill the whole
        // store first so that any later window length only scans written
        // entries. Corner samples lead, the rest is random.
        tx_idle_pct = 20;
        rx_idle_pct <= 20;
        foreach (corner_samples[k])
            send_sample(corner_samples[k]);
        repeat (FILL_ITEMS - 8) send_sample(WRSD_SAMPLE_BITS'($urandom));

        // Directed settings.
        // max tolerance over the full store: always stable
        run_phase(WRSD_STORE_DEPTH, 25'h1FFFFFF, 3, MODE_WIDE, 0, 0, 0, 1'b0);
        // window of one, shrunk below the current write index
        run_phase(1, 25'd1, 4, MODE_WIDE, 0, 10, 10, 1'b0);
        // length zero acts as one; zero tolerance is never stable
        run_phase(0, 25'd0, 3, MODE_WIDE, 0, 10, 10, 1'b0);
        // full-scale range just misses a tolerance of 2^24-1
        run_phase(2, 25'hFFFFFF, 4, MODE_CORNER, 0, 0, 0, 1'b0);
        // length above store depth saturates; 2^24 clears any range
        run_phase(1023, 25'h1000000, 2, MODE_CORNER, 0, 0, 0, 1'b0);
        // long receiver hold-off with the sender still pushing
        run_phase(4, 25'd200, 24, MODE_CLUSTER, 255, 0, 0, 1'b1);

        // Random settings, mostly short windows; the last stretch runs flat out.
        while (sent < TOTAL_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 2)       len = 0;
            else if (pick < 55) len = $urandom_range(1, 8);
            else if (pick < 85) len = $urandom_range(9, 40);
            else if (pick < 96) len = $urandom_range(41, 160);
            else                len = $urandom_range(500, 1023);

            if (len <= 40)       count = $urandom_range(12, 40);
            else if (len <= 160) count = $urandom_range(3, 8);
            else                 count = $urandom_range(2, 3);

            pick = $urandom_range(99);
            if (pick < 25) begin
                mode = MODE_WIDE;
                spread = 24'hFFFFFF;
            end else if (pick < 85) begin
                mode = MODE_CLUSTER;
                spread = $urandom_range(0, 1 << $urandom_range(0, 23));
            end else begin
                mode = MODE_CORNER;
                spread = 24'hFFFFFF;
            end

            // tolerance mostly near the expected range so both verdicts show up
            pick = $urandom_range(99);
            if (pick < 45)      tol = TOL_BITS'(spread + $urandom_range(0, 2)) - 1'b1;
            else if (pick < 60) tol = TOL_BITS'($urandom_range(0, spread));
            else if (pick < 70) tol = '0;
            else if (pick < 78) tol = '1;
            else                tol = TOL_BITS'($urandom);
            if (spread == 0 && pick < 45 && tol == '1)
                tol = '0;

            if (TOTAL_ITEMS - sent <= QUIET_ITEMS) begin
                tx_pct = 0;
                rx_pct = 0;
                hold = 1'b0;
            end else begin
                pick = $urandom_range(2);
                tx_pct = (pick == 0) ? 0 : ((pick == 1) ? 15 : 40);
                pick = $urandom_range(2);
                rx_pct = (pick == 0) ? 0 : ((pick == 1) ? 15 : 40);
                hold = ($urandom_range(99) < 4) && (len <= 40);
            end
            run_phase(len, tol, count, mode, spread, tx_pct, rx_pct, hold);
        end

        // Drain, then let a full-length scan's worth of cycles pass for strays.
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### files.f
rtl/wrsd_pkg.sv
rtl/wrsd_ctrl.sv
rtl/wrsd_datapath.sv
rtl/window_range_stability_detector_core.sv
bench/wrsd_result_checker.sv
bench/window_range_stability_detector_core_test.sv
